[rtl/lbe_pkg.sv]
// ----------------------------------------------------------------------------
// lbe_pkg
// types, constants and helpers shared by the lagrange basis evaluator
// ----------------------------------------------------------------------------
package lbe_pkg;

  localparam int MaxNodes  = 8;
  localparam int ResultCap = 8;
  localparam int NodeCap   = (MaxNodes < ResultCap) ? MaxNodes : ResultCap;
  localparam int AddrW     = $clog2(MaxNodes);
  localparam int IdxW      = (NodeCap > 1) ? $clog2(NodeCap) : 1;
  localparam int CntW      = $clog2(NodeCap + 1);
  localparam int SumW      = 42;

  localparam logic signed [31:0] QOne    = 32'sh0100_0000;
  localparam logic signed [63:0] QHalf   = 64'sh0000_0000_0080_0000;
  localparam logic signed [31:0] SatMax  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SatMin  = 32'sh8000_0000;
  localparam logic [1:0]         DerivLvl1 = 2'd1;
  localparam logic [1:0]         DerivLvl2 = 2'd2;

  typedef enum logic {
    ReqLoad = 1'b0,
    ReqEval = 1'b1
  } lbe_req_e;

  typedef enum logic [2:0] {
    DstSecond,
    DstFirst,
    DstValue,
    DstResV,
    DstResF,
    DstResS
  } lbe_dst_e;

  typedef enum logic [3:0] {
    StIdle,
    StDiff,
    StMulS,
    StMulF,
    StMulV,
    StWtV,
    StWtF,
    StWtS,
    StDrain,
    StOut
  } lbe_state_e;

  typedef struct packed {
    logic               req_type;
    logic [2:0]         entry_index;
    logic signed [31:0] node_coord;
    logic signed [31:0] node_weight;
    logic signed [31:0] x_point;
    logic [1:0]         deriv_level;
  } lbe_in_t;

  typedef struct packed {
    logic [2:0]         node_index;
    logic signed [31:0] basis_value;
    logic signed [31:0] first_deriv;
    logic signed [31:0] second_deriv;
    logic               last_of_run;
  } lbe_out_t;

  typedef struct packed {
    logic               issue;
    lbe_dst_e           dst;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [32:0] addend;
  } lbe_mac_op_t;

  typedef struct packed {
    logic               vld;
    lbe_dst_e           dst;
    logic signed [31:0] data;
  } lbe_mac_res_t;

  function automatic logic signed [31:0] lbe_sat32(input logic signed [SumW-1:0] v);
    logic signed [31:0] r;
    if ((&v[SumW-1:31]) || !(|v[SumW-1:31])) begin
      r = v[31:0];
    end else if (v[SumW-1]) begin
      r = SatMin;
    end else begin
      r = SatMax;
    end
    return r;
  endfunction

endpackage

[rtl/lbe_table.sv]
// ----------------------------------------------------------------------------
// lbe_table
// node coordinate and weight storage, one write port, one read port each
// ----------------------------------------------------------------------------
module lbe_table import lbe_pkg::*; (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        wr_addr_i,
  input  logic signed [31:0]      wr_node_i,
  input  logic signed [31:0]      wr_weight_i,
  input  logic [AddrW-1:0]        node_addr_i,
  input  logic [AddrW-1:0]        weight_addr_i,
  output logic signed [31:0]      node_o,
  output logic signed [31:0]      weight_o
);

  logic signed [31:0] node_mem [MaxNodes];
  logic signed [31:0] weight_mem [MaxNodes];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      node_mem[wr_addr_i]   <= wr_node_i;
      weight_mem[wr_addr_i] <= wr_weight_i;
    end
  end

  // registered read, data appears in the cycle after the address
  always_ff @(posedge clk_i) begin
    node_o   <= node_mem[node_addr_i];
    weight_o <= weight_mem[weight_addr_i];
  end

endmodule

[rtl/lbe_mac.sv]
// ----------------------------------------------------------------------------
// lbe_mac
// shared q8.24 multiplier: registered product, then round, add and saturate
// ----------------------------------------------------------------------------
module lbe_mac import lbe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lbe_mac_op_t  op_i,
  output lbe_mac_res_t res_o
);

  logic signed [63:0]     prod_q;
  logic signed [32:0]     addend_q;
  lbe_dst_e               dst_q;
  logic                   vld_q;
  logic signed [63:0]     rnd;
  logic signed [SumW-1:0] rnd_w;
  logic signed [SumW-1:0] add_w;
  logic signed [SumW-1:0] sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= op_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.issue) begin
      prod_q   <= op_i.op_a * op_i.op_b;
      addend_q <= op_i.addend;
      dst_q    <= op_i.dst;
    end
  end

  always_comb begin
    rnd        = (prod_q + QHalf) >>> 24;
    rnd_w      = rnd[SumW-1:0];
    add_w      = {{(SumW-33){addend_q[32]}}, addend_q};
    sum        = rnd_w + add_w;
    res_o.vld  = vld_q;
    res_o.dst  = dst_q;
    res_o.data = lbe_sat32(sum);
  end

endmodule

[rtl/lbe_seq.sv]
// ----------------------------------------------------------------------------
// lbe_seq
// sequencer: walks nodes and factors, drives the shared multiplier,
// keeps the product-rule accumulators and the result register
// ----------------------------------------------------------------------------
module lbe_seq import lbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lbe_in_t            in_data_i,
  input  logic [CntW-1:0]    n_active_i,
  input  logic signed [31:0] node_i,
  input  logic signed [31:0] weight_i,
  output logic [AddrW-1:0]   node_addr_o,
  output logic [AddrW-1:0]   weight_addr_o,
  output lbe_mac_op_t        mac_op_o,
  input  lbe_mac_res_t       mac_res_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lbe_out_t           out_data_o
);

  lbe_state_e          state_q, state_d;
  logic [IdxW-1:0]     i_q;
  logic [CntW-1:0]     j_q, j_d;
  logic [CntW-1:0]     n_q;
  logic [1:0]          lvl_q;
  logic                out_valid_q;
  lbe_out_t            out_q;
  logic signed [31:0]  x_q, f_q;
  logic signed [31:0]  value_q, first_q, second_q;
  logic signed [31:0]  resv_q, resf_q, ress_q;
  logic                eval_start;
  logic                j_done;
  logic                j_skip;
  logic                is_last;
  logic                out_load;
  logic signed [SumW-1:0] diff;

  assign j_done  = (j_q == n_q);
  assign j_skip  = (j_q == CntW'(i_q));
  assign is_last = ((CntW'(i_q) + CntW'(1)) == n_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i && (in_data_i.req_type == ReqEval)) state_d = StDiff;
      end
      StDiff: begin
        if (j_done) begin
          state_d = StWtV;
        end else if (!j_skip) begin
          state_d = StMulS;
        end
      end
      StMulS:  state_d = StMulF;
      StMulF:  state_d = StMulV;
      StMulV:  state_d = StDiff;
      StWtV:   state_d = StWtF;
      StWtF:   state_d = StWtS;
      StWtS:   state_d = StDrain;
      StDrain: state_d = StOut;
      StOut: begin
        if (!out_valid_q || out_ready_i) state_d = is_last ? StIdle : StDiff;
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    eval_start      = 1'b0;
    out_load        = 1'b0;
    mac_op_o.issue  = 1'b0;
    mac_op_o.dst    = DstValue;
    mac_op_o.op_a   = value_q;
    mac_op_o.op_b   = f_q;
    mac_op_o.addend = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        eval_start = in_valid_i && (in_data_i.req_type == ReqEval);
      end
      StMulS: begin
        mac_op_o.issue  = 1'b1;
        mac_op_o.dst    = DstSecond;
        mac_op_o.op_a   = second_q;
        mac_op_o.addend = {first_q, 1'b0};
      end
      StMulF: begin
        mac_op_o.issue  = 1'b1;
        mac_op_o.dst    = DstFirst;
        mac_op_o.op_a   = first_q;
        mac_op_o.addend = {value_q[31], value_q};
      end
      StMulV: begin
        mac_op_o.issue = 1'b1;
        mac_op_o.dst   = DstValue;
      end
      StWtV: begin
        mac_op_o.issue = 1'b1;
        mac_op_o.dst   = DstResV;
        mac_op_o.op_b  = weight_i;
      end
      StWtF: begin
        mac_op_o.issue = 1'b1;
        mac_op_o.dst   = DstResF;
        mac_op_o.op_a  = first_q;
        mac_op_o.op_b  = weight_i;
      end
      StWtS: begin
        mac_op_o.issue = 1'b1;
        mac_op_o.dst   = DstResS;
        mac_op_o.op_a  = second_q;
        mac_op_o.op_b  = weight_i;
      end
      StOut: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  // factor counter
  always_comb begin
    j_d = j_q;
    if (eval_start) begin
      j_d = '0;
    end else if ((state_q == StDiff) && !j_done) begin
      j_d = j_q + CntW'(1);
    end else if (out_load && !is_last) begin
      j_d = '0;
    end
  end

  // node read address is taken from j_d, the next value of j_q
  assign node_addr_o   = AddrW'(j_d);
  assign weight_addr_o = AddrW'(i_q);
  assign diff = {{(SumW-32){x_q[31]}}, x_q} - {{(SumW-32){node_i[31]}}, node_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= CntW'(1);
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      if (eval_start) begin
        n_q   <= n_active_i;
        lvl_q <= (in_data_i.deriv_level > DerivLvl2) ? DerivLvl2 : in_data_i.deriv_level;
        i_q   <= '0;
      end
      if (out_load && !is_last) begin
        i_q <= i_q + IdxW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_res_i.vld) begin
      case (mac_res_i.dst)
        DstSecond: second_q <= mac_res_i.data;
        DstFirst:  first_q  <= mac_res_i.data;
        DstValue:  value_q  <= mac_res_i.data;
        DstResV:   resv_q   <= mac_res_i.data;
        DstResF:   resf_q   <= mac_res_i.data;
        DstResS:   ress_q   <= mac_res_i.data;
        default: begin
        end
      endcase
    end
    if (eval_start) begin
      x_q      <= in_data_i.x_point;
      value_q  <= QOne;
      first_q  <= '0;
      second_q <= '0;
    end
    if ((state_q == StDiff) && !j_done && !j_skip) begin
      f_q <= lbe_sat32(diff);
    end
    if (out_load) begin
      out_q.node_index   <= 3'(i_q);
      out_q.basis_value  <= resv_q;
      out_q.first_deriv  <= (lvl_q >= DerivLvl1) ? resf_q : '0;
      out_q.second_deriv <= (lvl_q >= DerivLvl2) ? ress_q : '0;
      out_q.last_of_run  <= is_last;
      if (!is_last) begin
        value_q  <= QOne;
        first_q  <= '0;
        second_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_mac_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_res_i.vld |-> $past(mac_op_o.issue))
    else $error("multiplier result without an issue one cycle earlier");

  a_node_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> ((CntW'(i_q) < n_q) && (j_q <= n_q) && (n_q != '0)))
    else $error("node or factor counter out of range");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StOut))
    else $error("result beat raised outside the output step");

  a_no_mac_at_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |-> !mac_res_i.vld)
    else $error("multiplier still busy when the result is taken");

endmodule

[rtl/lagrange_1d_basis_eval.sv]
// ----------------------------------------------------------------------------
// lagrange_1d_basis_eval
// 1d lagrange basis values and derivatives in q8.24 on one shared multiplier
//
//   channel | direction | beat contents
//   --------+-----------+------------------------------------------------
//   in      | input     | load of one table entry, or evaluate at x
//   out     | output    | one basis result per active node, last marked
//   cfg     | input     | node_count (4 bits), always ready
//
// a load beat is written to the table as it is accepted; an evaluate beat
// with n active nodes runs its products one by one on the one shared
// multiplier (three products per factor, three per weight) and can stall
// on out. in is not ready during an evaluation. a finished result waits in
// an output register while the next node is computed. reset sets
// node_count to 2; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module lagrange_1d_basis_eval import lbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lbe_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output lbe_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i
);

  logic [3:0]         node_count_q;
  logic [CntW-1:0]    n_active;
  logic               tbl_we;
  logic [AddrW-1:0]   node_addr, weight_addr;
  logic signed [31:0] node_rd, weight_rd;
  lbe_mac_op_t        mac_op;
  lbe_mac_res_t       mac_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 4'd2;
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (node_count_q == 4'd0) begin
      n_active = CntW'(1);
    end else if (int'(node_count_q) > NodeCap) begin
      n_active = CntW'(NodeCap);
    end else begin
      n_active = CntW'(node_count_q);
    end
  end

  assign tbl_we = in_valid_i && in_ready_o && (in_data_i.req_type == ReqLoad) &&
                  (int'(in_data_i.entry_index) < MaxNodes);

  lbe_table u_table (
    .clk_i         (clk_i),
    .we_i          (tbl_we),
    .wr_addr_i     (AddrW'(in_data_i.entry_index)),
    .wr_node_i     (in_data_i.node_coord),
    .wr_weight_i   (in_data_i.node_weight),
    .node_addr_i   (node_addr),
    .weight_addr_i (weight_addr),
    .node_o        (node_rd),
    .weight_o      (weight_rd)
  );

  lbe_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .res_o  (mac_res)
  );

  lbe_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .n_active_i    (n_active),
    .node_i        (node_rd),
    .weight_i      (weight_rd),
    .node_addr_o   (node_addr),
    .weight_addr_o (weight_addr),
    .mac_op_o      (mac_op),
    .mac_res_i     (mac_res),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 1d lagrange basis evaluator. It loads the node
// and weight tables, sweeps node_count over legal and out-of-range settings,
// and sends directed and random evaluate beats. A built-in Q8.24 model
// predicts each basis result, which is checked field by field as it arrives.
// Both the input and the output channel get random stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lbe_pkg::*;

  localparam logic [1:0] DerivNone = 2'd0;
  localparam logic [1:0] DerivOver = 2'd3;
  localparam int         SettleCycles = 16;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  lbe_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  lbe_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = 4'd2;

  logic signed [31:0] coord_tbl [MaxNodes];
  logic signed [31:0] weight_tbl [MaxNodes];
  logic [3:0]         node_count_q = 4'd2;
  lbe_out_t           basis_q [$];

  int send_gap_pct = 27;
  int recv_gap_pct = 66;
  int errors = 0;
  int beats_in = 0;
  int evals = 0;
  int results_seen = 0;
  int cfg_writes = 0;

  lagrange_1d_basis_eval DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint sat_q824(longint v);
    if (v > longint'(SatMax)) return longint'(SatMax);
    if (v < longint'(SatMin)) return longint'(SatMin);
    return v;
  endfunction

  // round half up, floor of the arithmetic shift
  function automatic longint mul_q824(longint a, longint b);
    longint p;
    p = a * b + 64'sd8388608;
    return p >>> 24;
  endfunction

  function automatic void predict_item(lbe_in_t it);
    int       n;
    int       i;
    int       j;
    int       lvl;
    longint   x;
    longint   f;
    longint   val;
    longint   d1;
    longint   d2;
    longint   w;
    longint   t;
    lbe_out_t r;
    if (it.req_type == ReqLoad) begin
      coord_tbl[it.entry_index] = it.node_coord;
      weight_tbl[it.entry_index] = it.node_weight;
      return;
    end
    lvl = (it.deriv_level > DerivLvl2) ? 2 : int'(it.deriv_level);
    n = int'(node_count_q);
    if (n < 1) n = 1;
    if (n > NodeCap) n = NodeCap;
    x = longint'($signed(it.x_point));
    for (i = 0; i < n; i++) begin
      val = longint'(QOne);
      d1 = 0;
      d2 = 0;
      for (j = 0; j < n; j++) begin
        if (j != i) begin
          f = sat_q824(x - longint'(coord_tbl[j]));
          d2 = sat_q824(mul_q824(d2, f) + 2 * d1);
          d1 = sat_q824(mul_q824(d1, f) + val);
          val = sat_q824(mul_q824(val, f));
        end
      end
      w = longint'(weight_tbl[i]);
      r = '0;
      r.node_index = 3'(i);
      t = sat_q824(mul_q824(val, w));
      r.basis_value = t[31:0];
      if (lvl >= 1) begin
        t = sat_q824(mul_q824(d1, w));
        r.first_deriv = t[31:0];
      end
      if (lvl >= 2) begin
        t = sat_q824(mul_q824(d2, w));
        r.second_deriv = t[31:0];
      end
      r.last_of_run = (i == n - 1);
      basis_q.insert(basis_q.size(), r);
    end
  endfunction

  function automatic void match_result(lbe_out_t got);
    lbe_out_t want;
    results_seen++;
    if (basis_q.size() == 0) begin
      $error("unexpected result beat: node_index %0d", got.node_index);
      errors++;
      return;
    end
    want = basis_q.pop_front();
    if (got.node_index !== want.node_index) begin
      $error("node_index: expected %0d, got %0d", want.node_index, got.node_index);
      errors++;
    end
    if (got.basis_value !== want.basis_value) begin
      $error("basis_value: expected %h, got %h", want.basis_value, got.basis_value);
      errors++;
    end
    if (got.first_deriv !== want.first_deriv) begin
      $error("first_deriv: expected %h, got %h", want.first_deriv, got.first_deriv);
      errors++;
    end
    if (got.second_deriv !== want.second_deriv) begin
      $error("second_deriv: expected %h, got %h", want.second_deriv, got.second_deriv);
      errors++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) match_result(out_data);
    out_ready <= rst_n && ($urandom_range(99) >= recv_gap_pct);
  end

  // moderate values mostly, so the products do not all saturate
  function automatic logic signed [31:0] rand_q824();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
    if (pick < 90) return $urandom;
    if (pick < 95) return SatMax;
    return SatMin;
  endfunction

  function automatic lbe_in_t load_beat(logic [2:0] idx, logic signed [31:0] coord,
                                        logic signed [31:0] wgt);
    lbe_in_t it;
    it.req_type = ReqLoad;
    it.entry_index = idx;
    it.node_coord = coord;
    it.node_weight = wgt;
    it.x_point = $urandom;
    it.deriv_level = 2'($urandom);
    return it;
  endfunction

  function automatic lbe_in_t eval_beat(logic signed [31:0] x, logic [1:0] lvl);
    lbe_in_t it;
    it.req_type = ReqEval;
    it.entry_index = 3'($urandom);
    it.node_coord = $urandom;
    it.node_weight = $urandom;
    it.x_point = x;
    it.deriv_level = lvl;
    return it;
  endfunction

  // leaves in_valid high; wait_drained drops it
  task automatic send_item(lbe_in_t it);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
    beats_in++;
    if (it.req_type == ReqEval) evals++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (basis_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_node_count(logic [3:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    node_count_q = v;
    cfg_writes++;
  endtask

  task automatic test_table_fill();
    int k;
    for (k = 0; k < MaxNodes; k++) begin
      send_item(load_beat(3'(k), (2 * k - 7) * 32'sh0040_0000, QOne));
    end
  endtask

  task automatic test_node_count_limits();
    write_node_count(4'd0);
    send_item(eval_beat(32'sd0, DerivOver));
    write_node_count(4'd15);
    send_item(eval_beat(32'sh0040_0000, DerivLvl2));
    write_node_count(4'd1);
    send_item(eval_beat(-32'sh0100_0000, DerivNone));
  endtask

  task automatic test_field_extremes();
    write_node_count(4'd8);
    send_item(eval_beat(SatMax, DerivLvl2));
    send_item(eval_beat(SatMin, DerivLvl1));
    send_item(load_beat(3'd3, SatMin, SatMax));
    send_item(load_beat(3'd0, SatMax, SatMin));
    send_item(eval_beat(32'sd0, DerivLvl2));
    send_item(eval_beat(SatMax, DerivOver));
    send_item(load_beat(3'd7, 32'sd0, 32'sd0));
    send_item(eval_beat(QOne, DerivLvl2));
  endtask

  task automatic test_random_mix(int chunks, int per_chunk);
    int c;
    int k;
    for (c = 0; c < chunks; c++) begin
      write_node_count((c == 0) ? 4'd8 : 4'($urandom_range(15)));
      for (k = 0; k < per_chunk; k++) begin
        if ($urandom_range(99) < 30) begin
          send_item(load_beat(3'($urandom), rand_q824(), rand_q824()));
        end else begin
          send_item(eval_beat(rand_q824(), 2'($urandom)));
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_fill();
    test_node_count_limits();
    test_field_extremes();
    test_random_mix(5, 30);

    send_gap_pct = 66;
    recv_gap_pct = 27;
    test_random_mix(5, 30);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_mix(5, 30);

    wait_drained();
    $display("covered %0d input beats (%0d evaluations), %0d result beats, %0d node_count writes",
             beats_in, evals, results_seen, cfg_writes);
    $display("node_count 0..15, derivative levels 0..3, saturating and moderate operands");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
